### hw/rtl/packet_frame_timeline_table_defines.svh
// Assertion macros shared by the timeline table RTL.
// No dependencies; included by modules that carry assertions.
`ifndef PACKET_FRAME_TIMELINE_TABLE_DEFINES_SVH
`define PACKET_FRAME_TIMELINE_TABLE_DEFINES_SVH

// Property that must hold at every edge outside reset.
`define PFT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the condition.
`define PFT_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

### hw/rtl/pftt_pkg.sv
// Types and constants of the packet frame timeline table.
// No dependencies.
package pftt_pkg;

    localparam int unsigned SLOTS_DEFAULT = 64;
    localparam logic [6:0] SLOT_COUNT_RESET = 7'd64;

    typedef enum logic [2:0] {
        KIND_EXPOSE  = 3'd0,
        KIND_NODATA  = 3'd1,
        KIND_LOOK_FR = 3'd2,
        KIND_LOOK_IX = 3'd3,
        KIND_RESET   = 3'd4
    } kind_t;

    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_EXPOSED = 2'd1;
    localparam logic [1:0] ST_DONE    = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] packet_index;
        logic [47:0] buffer_addr;
        logic [15:0] buffer_capacity;
        logic [15:0] packet_size;
        logic        is_data;
        logic [47:0] first_frame;
        logic [7:0]  frame_count;
        logic [7:0]  block_size;
        logic [47:0] lookup_frame;
    } in_item_t;

    typedef struct packed {
        logic        ok;
        logic [5:0]  hit_slot;
        logic [31:0] hit_packet_index;
        logic [1:0]  hit_state;
        logic [47:0] hit_buffer_addr;
        logic [15:0] hit_packet_size;
        logic [47:0] hit_first_frame;
        logic [7:0]  hit_frame_count;
        logic [7:0]  hit_block_size;
        logic [31:0] hit_generation;
        logic [48:0] frame_high_water;
    } out_item_t;

    // One slot record as it sits in the memory (capacity is never read back).
    typedef struct packed {
        logic [31:0] packet_index;
        logic [47:0] buffer_addr;
        logic [15:0] size;
        logic        data_flag;
        logic [47:0] first_frame;
        logic [7:0]  frame_count;
        logic [7:0]  block_size;
        logic [1:0]  state;
        logic [31:0] generation;
    } slot_t;

endpackage

### hw/rtl/pftt_mem.sv
// Slot record memory: one write port, one registered read port.
// Depends on pftt_pkg.
module pftt_mem
    import pftt_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(SLOTS)-1:0] waddr,
    input  slot_t                    wdata,
    input  logic [$clog2(SLOTS)-1:0] raddr,
    output slot_t                    rdata
);
    slot_t mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/pftt_div.sv
// Serial restoring remainder of a 32-bit packet index by the slot count.
// Depends on pftt_pkg.
module pftt_div
    import pftt_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [31:0]              dividend,
    input  logic [$clog2(SLOTS):0]   divisor,
    output logic                     done,
    output logic [$clog2(SLOTS)-1:0] remainder
);
    localparam int unsigned RW = $clog2(SLOTS) + 1;

    logic [31:0]   quo_reg;
    logic [RW:0]   rem_reg;
    logic [5:0]    cnt_reg;
    logic          busy_reg;
    logic [RW:0]   trial;
    logic [RW:0]   shifted;

    assign shifted = {rem_reg[RW-1:0], quo_reg[31]};
    assign trial = shifted - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd32;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[30:0], 1'b0};
            rem_reg <= trial[RW] ? shifted : trial;
        end
    end

    assign done = busy_reg && (cnt_reg == 6'd1);
    // Remainder after the final step, valid in the cycle done is high.
    logic [RW:0] last_rem;
    assign last_rem = trial[RW] ? shifted : trial;
    assign remainder = last_rem[RW-2:0];
endmodule

### hw/rtl/packet_frame_timeline_table.sv
// Packet frame timeline table: a ring of packet slot records held in one synchronous
// memory, sequenced item by item. After reset the block first clears all SLOTS slot
// records, one per cycle, and takes no item until that sweep is done. Exposes, no-data
// marks and index lookups reduce the packet index modulo the slot count in a serial
// divider, then read one slot and, for no-data marks and accepted exposes, write it
// back (S_DIV, S_RD, S_MOD, S_OUT). A frame lookup reads the slots one per cycle
// through the memory's single read port and stops at the first hit, or after the n
// slots in use. A reset item sweeps slots 0..n-1 with one read and one write per slot.
// Other kinds go straight to a result with ok low. The result waits in an output
// register; the next item is taken only after the result beat has been accepted.
module packet_frame_timeline_table
    import pftt_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [6:0] cfg_data
);
    `include "packet_frame_timeline_table_defines.svh"

    localparam int unsigned AW = $clog2(SLOTS);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DIV   = 10'b0000000010,
        S_RD    = 10'b0000000100,
        S_MOD   = 10'b0000001000,
        S_SCAN  = 10'b0000010000,
        S_CLR_R = 10'b0000100000,
        S_CLR_W = 10'b0001000000,
        S_OUT   = 10'b0010000000,
        S_SWAIT = 10'b0100000000,
        S_INIT  = 10'b1000000000
    } state_t;

    state_t        state_reg, state_next;
    in_item_t      item_reg;
    logic [6:0]    cnt_cfg_reg;
    logic [AW:0]   n_eff;
    logic [48:0]   hw_reg;
    logic [AW:0]   ptr_reg;
    logic [AW-1:0] slot_reg;
    out_item_t     res_reg;
    logic          mval_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    slot_t         mem_wdata, mem_rdata;
    logic          div_done;
    logic [AW-1:0] div_rem;
    logic          div_start;

    always_comb begin
        if (cnt_cfg_reg == 7'd0) begin
            n_eff = (AW+1)'(1);
        end else if (32'(cnt_cfg_reg) > SLOTS) begin
            n_eff = (AW+1)'(SLOTS);
        end else begin
            n_eff = (AW+1)'(cnt_cfg_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign s_ready = (state_reg == S_IDLE) && !mval_reg;
    assign m_valid = mval_reg;
    assign m_data = res_reg;
    assign div_start = s_valid && s_ready;

    pftt_div #(.SLOTS(SLOTS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(s_data.packet_index), .divisor(n_eff),
        .done(div_done), .remainder(div_rem)
    );

    pftt_mem #(.SLOTS(SLOTS)) u_mem (
        .aclk(aclk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    // Slot record that the current item would write back.
    slot_t   upd;
    logic    expose_ok;
    logic [48:0] fr_end, scan_end;
    logic    scan_hit;

    assign expose_ok = (item_reg.buffer_addr != '0) && item_reg.is_data
        && (item_reg.frame_count != '0) && (item_reg.buffer_capacity >= item_reg.packet_size);
    assign fr_end = {1'b0, item_reg.first_frame} + 49'(item_reg.frame_count);
    assign scan_end = {1'b0, mem_rdata.first_frame} + 49'(mem_rdata.frame_count);
    assign scan_hit = (mem_rdata.state == ST_EXPOSED) && mem_rdata.data_flag
        && ({1'b0, item_reg.lookup_frame} >= {1'b0, mem_rdata.first_frame})
        && ({1'b0, item_reg.lookup_frame} < scan_end)
        && (mem_rdata.buffer_addr != '0) && (mem_rdata.block_size != '0);

    always_comb begin
        upd = '0;
        upd.generation = mem_rdata.generation + 32'd2;
        if (item_reg.kind == KIND_EXPOSE) begin
            upd.packet_index = item_reg.packet_index;
            upd.buffer_addr  = item_reg.buffer_addr;
            upd.size         = item_reg.packet_size;
            upd.data_flag    = 1'b1;
            upd.first_frame  = item_reg.first_frame;
            upd.frame_count  = item_reg.frame_count;
            upd.block_size   = item_reg.block_size;
            upd.state        = ST_EXPOSED;
        end else if (item_reg.kind == KIND_NODATA) begin
            upd.packet_index = item_reg.packet_index;
            upd.state        = ST_DONE;
        end
    end

    function automatic out_item_t emit(slot_t r, logic [AW-1:0] s);
        out_item_t o;
        o = '0;
        o.ok               = 1'b1;
        o.hit_slot         = 6'(s);
        o.hit_packet_index = r.packet_index;
        o.hit_state        = r.state;
        o.hit_buffer_addr  = r.buffer_addr;
        o.hit_packet_size  = r.size;
        o.hit_first_frame  = r.first_frame;
        o.hit_frame_count  = r.frame_count;
        o.hit_block_size   = r.block_size;
        o.hit_generation   = r.generation;
        return o;
    endfunction

    always_comb begin
        state_next = state_reg;
        mem_we = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = upd;
        mem_raddr = slot_reg;
        unique case (state_reg)
            S_INIT: begin
                // Every slot starts out empty with a zero write counter.
                mem_we = 1'b1;
                mem_waddr = ptr_reg[AW-1:0];
                mem_wdata = '0;
                if (ptr_reg == (AW+1)'(SLOTS - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (div_start) begin
                    unique case (s_data.kind)
                        KIND_EXPOSE, KIND_NODATA, KIND_LOOK_IX: state_next = S_DIV;
                        KIND_LOOK_FR: state_next = S_SCAN;
                        KIND_RESET:   state_next = S_CLR_R;
                        default:      state_next = S_OUT;
                    endcase
                end
            end
            S_DIV: begin
                mem_raddr = div_rem;
                if (div_done) state_next = S_RD;
            end
            S_RD:  state_next = S_MOD;
            S_MOD: begin
                mem_we = (item_reg.kind == KIND_NODATA)
                    || (item_reg.kind == KIND_EXPOSE && expose_ok);
                state_next = S_OUT;
            end
            S_SCAN: begin
                // ptr_reg counts reads issued; data of slot ptr-1 is present after the first.
                mem_raddr = ptr_reg[AW-1:0];
                if (ptr_reg != '0 && (scan_hit || ptr_reg == n_eff + (AW+1)'(1)))
                    state_next = S_OUT;
            end
            S_CLR_R: begin
                mem_raddr = ptr_reg[AW-1:0];
                state_next = (ptr_reg == n_eff) ? S_OUT : S_CLR_W;
            end
            S_CLR_W: begin
                mem_we = 1'b1;
                mem_waddr = ptr_reg[AW-1:0];
                state_next = S_CLR_R;
            end
            S_OUT:   state_next = S_SWAIT;
            S_SWAIT: if (!mval_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    logic [48:0] hw_next;
    always_comb begin
        hw_next = hw_reg;
        if (state_reg == S_MOD && item_reg.kind == KIND_EXPOSE && expose_ok
            && fr_end > hw_reg) begin
            hw_next = fr_end;
        end else if (state_reg == S_CLR_R && item_reg.kind == KIND_RESET) begin
            hw_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            cnt_cfg_reg <= SLOT_COUNT_RESET;
            hw_reg      <= '0;
            mval_reg    <= 1'b0;
            ptr_reg     <= '0;
            res_reg     <= '0;
        end else begin
            state_reg <= state_next;
            hw_reg    <= hw_next;
            if (cfg_valid && cfg_ready) cnt_cfg_reg <= cfg_data;
            if (mval_reg && m_ready) mval_reg <= 1'b0;
            if (state_reg == S_INIT) ptr_reg <= ptr_reg + (AW+1)'(1);
            if (div_start) begin
                item_reg <= s_data;
                ptr_reg  <= '0;
                res_reg  <= '0;
            end
            if (state_reg == S_DIV && div_done) slot_reg <= div_rem;
            if (state_reg == S_MOD) begin
                if (item_reg.kind == KIND_EXPOSE) begin
                    if (expose_ok) res_reg <= emit(upd, slot_reg);
                end else if (item_reg.kind == KIND_NODATA) begin
                    res_reg <= emit(upd, slot_reg);
                end else if (mem_rdata.state != ST_EMPTY
                             && mem_rdata.packet_index == item_reg.packet_index) begin
                    res_reg <= emit(mem_rdata, slot_reg);
                end
            end
            if (state_reg == S_SCAN) begin
                ptr_reg <= ptr_reg + (AW+1)'(1);
                if (ptr_reg != '0 && ptr_reg <= n_eff && scan_hit)
                    res_reg <= emit(mem_rdata, AW'(ptr_reg - (AW+1)'(1)));
            end
            if (state_reg == S_CLR_R) res_reg.ok <= 1'b1;
            if (state_reg == S_CLR_W) ptr_reg <= ptr_reg + (AW+1)'(1);
            if (state_reg == S_OUT) begin
                mval_reg <= 1'b1;
                res_reg.frame_high_water <= hw_reg;
            end
        end
    end

    // In the clear sweep the generation still advances, since upd always takes the read generation plus two.
    // (Reset items leave kind at KIND_RESET, where upd is the cleared record.)

    `PFT_ASSERT(a_ready_idle, aclk, aresetn, !(s_ready && mval_reg),
        "input taken while a result is pending")
    `PFT_ASSERT(a_no_write_idle, aclk, aresetn, !(mem_we && state_reg == S_IDLE),
        "memory written while idle")
    `PFT_ASSERT_NEXT(a_out_valid, aclk, aresetn, state_reg == S_OUT, mval_reg,
        "result not presented after completion")
endmodule

### test/pftt_checker.sv
// Checker for the packet frame timeline table: watches the item, result and
// configuration channels, predicts each result and compares. Uses pftt_pkg.
`timescale 1ns / 100ps

module pftt_checker
    import pftt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  in_item_t   s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  out_item_t  m_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [6:0] cfg_data,
    output int         fail_count,
    output int         pending_count
);

    localparam int NSLOT = 64;

    logic [31:0] tbl_pidx  [NSLOT];
    logic [47:0] tbl_addr  [NSLOT];
    logic [15:0] tbl_size  [NSLOT];
    logic        tbl_data  [NSLOT];
    logic [47:0] tbl_first [NSLOT];
    logic [7:0]  tbl_fcnt  [NSLOT];
    logic [7:0]  tbl_bsize [NSLOT];
    logic [1:0]  tbl_state [NSLOT];
    logic [31:0] tbl_gen   [NSLOT];
    logic [48:0] mark;
    logic [6:0]  slot_cfg;
    out_item_t   expected_q[$];

    assign pending_count = expected_q.size();

    function automatic out_item_t slot_view(int s);
        out_item_t r;
        r = '0;
        r.ok = 1'b1;
        r.hit_slot = s[5:0];
        r.hit_packet_index = tbl_pidx[s];
        r.hit_state = tbl_state[s];
        r.hit_buffer_addr = tbl_addr[s];
        r.hit_packet_size = tbl_size[s];
        r.hit_first_frame = tbl_first[s];
        r.hit_frame_count = tbl_fcnt[s];
        r.hit_block_size = tbl_bsize[s];
        r.hit_generation = tbl_gen[s];
        return r;
    endfunction

    task automatic wipe_slot(int s, logic [31:0] idx, logic [1:0] st);
        tbl_pidx[s] = idx;
        tbl_addr[s] = '0;
        tbl_size[s] = '0;
        tbl_data[s] = 1'b0;
        tbl_first[s] = '0;
        tbl_fcnt[s] = '0;
        tbl_bsize[s] = '0;
        tbl_state[s] = st;
        tbl_gen[s] = tbl_gen[s] + 32'd2;
    endtask

    task automatic predict_item(in_item_t it);
        out_item_t r;
        int n;
        int s;
        logic [48:0] top;
        logic [48:0] lim;
        r = '0;
        n = (slot_cfg == 0) ? 1 : ((slot_cfg > NSLOT) ? NSLOT : int'(slot_cfg));
        s = int'(it.packet_index % n);
        case (it.kind)
            KIND_EXPOSE: begin
                if (it.buffer_addr != 0 && it.is_data && it.frame_count != 0 &&
                    it.buffer_capacity >= it.packet_size) begin
                    tbl_pidx[s] = it.packet_index;
                    tbl_addr[s] = it.buffer_addr;
                    tbl_size[s] = it.packet_size;
                    tbl_data[s] = 1'b1;
                    tbl_first[s] = it.first_frame;
                    tbl_fcnt[s] = it.frame_count;
                    tbl_bsize[s] = it.block_size;
                    tbl_state[s] = ST_EXPOSED;
                    tbl_gen[s] = tbl_gen[s] + 32'd2;
                    top = {1'b0, it.first_frame} + it.frame_count;
                    if (top > mark) mark = top;
                    r = slot_view(s);
                end
            end
            KIND_NODATA: begin
                wipe_slot(s, it.packet_index, ST_DONE);
                r = slot_view(s);
            end
            KIND_LOOK_FR: begin
                for (int i = 0; i < n; i++) begin
                    lim = {1'b0, tbl_first[i]} + tbl_fcnt[i];
                    if (tbl_state[i] == ST_EXPOSED && tbl_data[i] &&
                        it.lookup_frame >= tbl_first[i] && {1'b0, it.lookup_frame} < lim &&
                        tbl_addr[i] != 0 && tbl_bsize[i] != 0) begin
                        r = slot_view(i);
                        break;
                    end
                end
            end
            KIND_LOOK_IX: begin
                if (tbl_state[s] != ST_EMPTY && tbl_pidx[s] == it.packet_index)
                    r = slot_view(s);
            end
            KIND_RESET: begin
                mark = '0;
                for (int i = 0; i < n; i++) wipe_slot(i, 32'd0, ST_EMPTY);
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.frame_high_water = mark;
        expected_q.push_back(r);
    endtask

    task automatic compare_result(out_item_t got);
        out_item_t e;
        if (expected_q.size() == 0) begin
            $error("result beat with nothing expected");
            fail_count++;
            return;
        end
        e = expected_q.pop_front();
        if (got.ok !== e.ok) begin
            $error("ok: expected %h, got %h", e.ok, got.ok); fail_count++;
        end
        if (got.hit_slot !== e.hit_slot) begin
            $error("hit_slot: expected %h, got %h", e.hit_slot, got.hit_slot); fail_count++;
        end
        if (got.hit_packet_index !== e.hit_packet_index) begin
            $error("hit_packet_index: expected %h, got %h",
                   e.hit_packet_index, got.hit_packet_index); fail_count++;
        end
        if (got.hit_state !== e.hit_state) begin
            $error("hit_state: expected %h, got %h", e.hit_state, got.hit_state); fail_count++;
        end
        if (got.hit_buffer_addr !== e.hit_buffer_addr) begin
            $error("hit_buffer_addr: expected %h, got %h",
                   e.hit_buffer_addr, got.hit_buffer_addr); fail_count++;
        end
        if (got.hit_packet_size !== e.hit_packet_size) begin
            $error("hit_packet_size: expected %h, got %h",
                   e.hit_packet_size, got.hit_packet_size); fail_count++;
        end
        if (got.hit_first_frame !== e.hit_first_frame) begin
            $error("hit_first_frame: expected %h, got %h",
                   e.hit_first_frame, got.hit_first_frame); fail_count++;
        end
        if (got.hit_frame_count !== e.hit_frame_count) begin
            $error("hit_frame_count: expected %h, got %h",
                   e.hit_frame_count, got.hit_frame_count); fail_count++;
        end
        if (got.hit_block_size !== e.hit_block_size) begin
            $error("hit_block_size: expected %h, got %h",
                   e.hit_block_size, got.hit_block_size); fail_count++;
        end
        if (got.hit_generation !== e.hit_generation) begin
            $error("hit_generation: expected %h, got %h",
                   e.hit_generation, got.hit_generation); fail_count++;
        end
        if (got.frame_high_water !== e.frame_high_water) begin
            $error("frame_high_water: expected %h, got %h",
                   e.frame_high_water, got.frame_high_water); fail_count++;
        end
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSLOT; i++) begin
                tbl_pidx[i] = '0; tbl_addr[i] = '0; tbl_size[i] = '0; tbl_data[i] = 1'b0;
                tbl_first[i] = '0; tbl_fcnt[i] = '0; tbl_bsize[i] = '0;
                tbl_state[i] = ST_EMPTY; tbl_gen[i] = '0;
            end
            mark = '0;
            slot_cfg = SLOT_COUNT_RESET;
            expected_q.delete();
        end else begin
            // Results are checked before the new item is predicted in the same edge.
            if (m_valid && m_ready) compare_result(m_data);
            if (cfg_valid && cfg_ready) slot_cfg = cfg_data;
            if (s_valid && s_ready) predict_item(s_data);
        end
    end

endmodule

### test/packet_frame_timeline_table_tb.sv
// Testbench top for the packet frame timeline table: drives items, slot count
// writes and result stalls; depends on pftt_pkg, pftt_checker and the block.
`timescale 1ns / 100ps

module packet_frame_timeline_table_tb;
    import pftt_pkg::*;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;
    int         fail_count;
    int         pending_count;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         hold_cycles;
    logic [31:0] recent_idx[$];
    logic [47:0] recent_frame[$];

    packet_frame_timeline_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    pftt_checker checker_inst (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random stalls, or a long counted hold-off when requested.
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic in_item_t random_item();
        in_item_t it;
        logic [255:0] raw;
        int pick;
        raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom()};
        it = raw[$bits(in_item_t)-1:0];
        pick = $urandom_range(99);
        if (pick < 45) it.kind = KIND_EXPOSE;
        else if (pick < 55) it.kind = KIND_NODATA;
        else if (pick < 75) it.kind = KIND_LOOK_FR;
        else if (pick < 90) it.kind = KIND_LOOK_IX;
        else if (pick < 94) it.kind = KIND_RESET;
        else it.kind = 3'($urandom_range(7));
        // Mostly well-formed exposes with small frame numbers so lookups hit.
        if ($urandom_range(9) < 8) begin
            it.is_data = 1'b1;
            if (it.buffer_addr == 0) it.buffer_addr = 48'd1;
            if (it.frame_count == 0) it.frame_count = 8'd1;
            it.packet_size = 16'($urandom_range(int'(it.buffer_capacity)));
            if ($urandom_range(3) != 0) begin
                it.first_frame = 48'($urandom_range(4000));
                it.packet_index = $urandom_range(300);
            end
        end
        if (recent_idx.size() > 0 && $urandom_range(1))
            it.packet_index = recent_idx[$urandom_range(recent_idx.size() - 1)];
        if (recent_frame.size() > 0 && $urandom_range(3) != 0)
            it.lookup_frame = recent_frame[$urandom_range(recent_frame.size() - 1)]
                              + 48'($urandom_range(3));
        if (it.kind == KIND_EXPOSE || it.kind == KIND_NODATA) begin
            recent_idx.push_back(it.packet_index);
            if (recent_idx.size() > 32) void'(recent_idx.pop_front());
        end
        if (it.kind == KIND_EXPOSE) begin
            recent_frame.push_back(it.first_frame);
            if (recent_frame.size() > 32) void'(recent_frame.pop_front());
        end
        return it;
    endfunction

    // Valid stays up after the accepting edge; the next call (when it idles) or drain()
    // takes it down, so back-to-back beats never assign it twice in one step.
    task automatic send_item(in_item_t it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_slot_count(logic [6:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_built(logic [2:0] k, logic [31:0] idx, logic [47:0] addr,
                              logic [15:0] cap, logic [15:0] sz, logic dat,
                              logic [47:0] first, logic [7:0] cnt, logic [7:0] bs,
                              logic [47:0] look);
        in_item_t it;
        it = '{k, idx, addr, cap, sz, dat, first, cnt, bs, look};
        send_item(it);
    endtask

    initial begin
        int settings[6];
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, every kind, each refusal reason and lookup edge.
        send_built(KIND_LOOK_FR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_built(KIND_LOOK_IX, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_built(KIND_EXPOSE, 5, 0, 100, 10, 1, 10, 4, 2, 0);
        send_built(KIND_EXPOSE, 5, 48'h1000, 100, 10, 0, 10, 4, 2, 0);
        send_built(KIND_EXPOSE, 5, 48'h1000, 100, 10, 1, 10, 0, 2, 0);
        send_built(KIND_EXPOSE, 5, 48'h1000, 9, 10, 1, 10, 4, 2, 0);
        send_built(KIND_EXPOSE, 5, 48'h1000, 10, 10, 1, 10, 4, 2, 0);
        send_built(KIND_LOOK_FR, 0, 0, 0, 0, 0, 0, 0, 0, 9);
        send_built(KIND_LOOK_FR, 0, 0, 0, 0, 0, 0, 0, 0, 10);
        send_built(KIND_LOOK_FR, 0, 0, 0, 0, 0, 0, 0, 0, 13);
        send_built(KIND_LOOK_FR, 0, 0, 0, 0, 0, 0, 0, 0, 14);
        send_built(KIND_EXPOSE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 1,
                   48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF, 0);
        send_built(KIND_LOOK_FR, 0, 0, 0, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
        send_built(KIND_LOOK_IX, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
        send_built(KIND_LOOK_IX, 32'hFFFF_FFBF, 0, 0, 0, 0, 0, 0, 0, 0);
        send_built(KIND_EXPOSE, 6, 48'h2000, 50, 0, 1, 100, 8, 0, 0);
        send_built(KIND_LOOK_FR, 0, 0, 0, 0, 0, 0, 0, 0, 101);
        send_built(KIND_NODATA, 69, 0, 0, 0, 0, 0, 0, 0, 0);
        send_built(KIND_LOOK_IX, 69, 0, 0, 0, 0, 0, 0, 0, 0);
        send_built(KIND_LOOK_IX, 5, 0, 0, 0, 0, 0, 0, 0, 0);
        send_built(3'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_built(3'd7, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 1,
                   48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF);
        send_built(KIND_RESET, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        // Slot counts with their extremes, including the out-of-range ones.
        settings = '{64, 1, 0, 7, 127, 17};
        for (int ph = 0; ph < 6; ph++) begin
            write_slot_count(settings[ph][6:0]);
            send_built(KIND_RESET, 0, 0, 0, 0, 0, 0, 0, 0, 0);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            if (ph == 2) hold_cycles <= 2000;
            for (int k = 0; k < 75; k++) begin
                send_item(random_item());
                if (ph == 4 && k == 30) drain();
            end
            send_idle_pct = 0;
            recv_stall_pct = 0;
        end

        drain();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
